### sv/fim_pkg.sv
// ----------------------------------------------------------------------------
// fim_pkg: shared definitions for the fuzzy intensity map
// Register indexes, reset values and the pipeline control word type.
// ----------------------------------------------------------------------------
package fim_pkg;

  localparam int PIXEL_BITS_DFLT = 8;
  localparam int CFG_IDX_BITS    = 3;

  // Register reset values
  localparam int RST_BREAK_LOW    = 10;
  localparam int RST_BREAK_MID    = 98;
  localparam int RST_BREAK_HIGH   = 250;
  localparam int RST_LEVEL_DARK   = 0;
  localparam int RST_LEVEL_GRAY   = 127;
  localparam int RST_LEVEL_BRIGHT = 255;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BREAK_LOW    = 3'd0,
    CFG_BREAK_MID    = 3'd1,
    CFG_BREAK_HIGH   = 3'd2,
    CFG_LEVEL_DARK   = 3'd3,
    CFG_LEVEL_GRAY   = 3'd4,
    CFG_LEVEL_BRIGHT = 3'd5
  } cfg_idx_e;

  // Control that travels with each word down the pipeline
  typedef struct packed {
    logic valid;   // stage holds a word
    logic bypass;  // result is a plain level, no ramp division
  } ctl_t;

endpackage

### sv/fuzzy_intensity_map_core.sv
// ----------------------------------------------------------------------------
// fuzzy_intensity_map_core: fuzzy ramp contrast mapping of gray pixels
// A word passes the blend stages, the divider stages and the output register.
// Throughput: one word per cycle unless the output stalls; the divider retires
//   one quotient bit per stage, so its depth sets the latency but not the rate.
// A stalled output word freezes every stage at once; nothing is dropped.
// Reset clears all valid bits and loads the break and level registers.
// ----------------------------------------------------------------------------
module fuzzy_intensity_map_core
  import fim_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DFLT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [PIXEL_BITS-1:0]   cfg_wdata_i,
  // pixel input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PIXEL_BITS-1:0]   pixel_in_i,
  // pixel output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PIXEL_BITS-1:0]   pixel_out_o
);

  localparam int W = PIXEL_BITS;

  logic [W-1:0] brk_low, brk_mid, brk_high;
  logic [W-1:0] lvl_dark, lvl_gray, lvl_bright;

  // Advance the whole pipe unless the output word is held by the sink.
  // The output register is the only place a finished word can wait, so
  // bubbles in the pipe are fine and a stall loses nothing.
  logic pipe_en;
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  fim_cfg #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .brk_low_o    (brk_low),
    .brk_mid_o    (brk_mid),
    .brk_high_o   (brk_high),
    .lvl_dark_o   (lvl_dark),
    .lvl_gray_o   (lvl_gray),
    .lvl_bright_o (lvl_bright)
  );

  // Front end: pick the ramp (or a plain level), weight, sum the numerator
  ctl_t           bl_ctl;
  logic [2*W-1:0] bl_num;
  logic [W-1:0]   bl_span, bl_lvl;

  fim_blend #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (pipe_en),
    .in_valid_i   (in_valid_i),
    .pixel_i      (pixel_in_i),
    .brk_low_i    (brk_low),
    .brk_mid_i    (brk_mid),
    .brk_high_i   (brk_high),
    .lvl_dark_i   (lvl_dark),
    .lvl_gray_i   (lvl_gray),
    .lvl_bright_i (lvl_bright),
    .ctl_o        (bl_ctl),
    .num_o        (bl_num),
    .span_o       (bl_span),
    .level_o      (bl_lvl)
  );

  // Back end: exact truncating division by the ramp span
  ctl_t         dv_ctl;
  logic [W-1:0] dv_quot, dv_lvl;

  fim_divider #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .ctl_i   (bl_ctl),
    .num_i   (bl_num),
    .span_i  (bl_span),
    .level_i (bl_lvl),
    .ctl_o   (dv_ctl),
    .quot_o  (dv_quot),
    .level_o (dv_lvl)
  );

  // Output register: plain levels skip the quotient
  logic         out_valid_q;
  logic [W-1:0] pixel_out_d, pixel_out_q;

  assign pixel_out_d = dv_ctl.bypass ? dv_lvl : dv_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= dv_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pixel_out_q <= pixel_out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;

endmodule

### sv/fim_cfg.sv
// ----------------------------------------------------------------------------
// fim_cfg: configuration register file
// Six write-only registers loaded through a plain write port.
// ----------------------------------------------------------------------------
module fim_cfg
  import fim_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DFLT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [PIXEL_BITS-1:0]   cfg_wdata_i,
  output logic [PIXEL_BITS-1:0]   brk_low_o,
  output logic [PIXEL_BITS-1:0]   brk_mid_o,
  output logic [PIXEL_BITS-1:0]   brk_high_o,
  output logic [PIXEL_BITS-1:0]   lvl_dark_o,
  output logic [PIXEL_BITS-1:0]   lvl_gray_o,
  output logic [PIXEL_BITS-1:0]   lvl_bright_o
);

  logic [PIXEL_BITS-1:0] brk_low_q, brk_mid_q, brk_high_q;
  logic [PIXEL_BITS-1:0] lvl_dark_q, lvl_gray_q, lvl_bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_low_q    <= PIXEL_BITS'(RST_BREAK_LOW);
      brk_mid_q    <= PIXEL_BITS'(RST_BREAK_MID);
      brk_high_q   <= PIXEL_BITS'(RST_BREAK_HIGH);
      lvl_dark_q   <= PIXEL_BITS'(RST_LEVEL_DARK);
      lvl_gray_q   <= PIXEL_BITS'(RST_LEVEL_GRAY);
      lvl_bright_q <= PIXEL_BITS'(RST_LEVEL_BRIGHT);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BREAK_LOW:    brk_low_q    <= cfg_wdata_i;
        CFG_BREAK_MID:    brk_mid_q    <= cfg_wdata_i;
        CFG_BREAK_HIGH:   brk_high_q   <= cfg_wdata_i;
        CFG_LEVEL_DARK:   lvl_dark_q   <= cfg_wdata_i;
        CFG_LEVEL_GRAY:   lvl_gray_q   <= cfg_wdata_i;
        CFG_LEVEL_BRIGHT: lvl_bright_q <= cfg_wdata_i;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  assign brk_low_o    = brk_low_q;
  assign brk_mid_o    = brk_mid_q;
  assign brk_high_o   = brk_high_q;
  assign lvl_dark_o   = lvl_dark_q;
  assign lvl_gray_o   = lvl_gray_q;
  assign lvl_bright_o = lvl_bright_q;

endmodule

### sv/fim_blend.sv
// ----------------------------------------------------------------------------
// fim_blend: classify, weight and sum
// Three stages: pick the ramp and its weights, multiply, add numerator.
// ----------------------------------------------------------------------------
module fim_blend
  import fim_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DFLT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    in_valid_i,
  input  logic [PIXEL_BITS-1:0]   pixel_i,
  input  logic [PIXEL_BITS-1:0]   brk_low_i,
  input  logic [PIXEL_BITS-1:0]   brk_mid_i,
  input  logic [PIXEL_BITS-1:0]   brk_high_i,
  input  logic [PIXEL_BITS-1:0]   lvl_dark_i,
  input  logic [PIXEL_BITS-1:0]   lvl_gray_i,
  input  logic [PIXEL_BITS-1:0]   lvl_bright_i,
  output ctl_t                    ctl_o,
  output logic [2*PIXEL_BITS-1:0] num_o,
  output logic [PIXEL_BITS-1:0]   span_o,
  output logic [PIXEL_BITS-1:0]   level_o
);

  localparam int W  = PIXEL_BITS;
  localparam int W2 = 2 * PIXEL_BITS;

  // Stage 1: ramp selection
  ctl_t         s1_ctl_d, s1_ctl_q;
  logic [W-1:0] s1_a_d, s1_b_d, s1_wa_d, s1_wb_d, s1_span_d, s1_lvl_d;
  logic [W-1:0] s1_a_q, s1_b_q, s1_wa_q, s1_wb_q, s1_span_q, s1_lvl_q;

  always_comb begin
    s1_ctl_d.valid  = in_valid_i;
    s1_ctl_d.bypass = 1'b0;
    s1_a_d    = '0;
    s1_b_d    = '0;
    s1_wa_d   = '0;
    s1_wb_d   = '0;
    s1_span_d = '0;
    s1_lvl_d  = '0;
    if (pixel_i <= brk_low_i) begin
      s1_ctl_d.bypass = 1'b1;
      s1_lvl_d        = lvl_dark_i;
    end else if (pixel_i >= brk_high_i) begin
      s1_ctl_d.bypass = 1'b1;
      s1_lvl_d        = lvl_bright_i;
    end else if (pixel_i < brk_mid_i) begin
      s1_a_d    = lvl_dark_i;
      s1_b_d    = lvl_gray_i;
      s1_wa_d   = brk_mid_i - pixel_i;
      s1_wb_d   = pixel_i - brk_low_i;
      s1_span_d = brk_mid_i - brk_low_i;
    end else begin
      s1_a_d    = lvl_gray_i;
      s1_b_d    = lvl_bright_i;
      s1_wa_d   = brk_high_i - pixel_i;
      s1_wb_d   = pixel_i - brk_mid_i;
      s1_span_d = brk_high_i - brk_mid_i;
    end
  end

  // Stage 2: weight products
  ctl_t          s2_ctl_q;
  logic [W2-1:0] s2_pa_d, s2_pb_d, s2_pa_q, s2_pb_q;
  logic [W-1:0]  s2_span_q, s2_lvl_q;

  assign s2_pa_d = W2'(s1_a_q) * W2'(s1_wa_q);
  assign s2_pb_d = W2'(s1_b_q) * W2'(s1_wb_q);

  // Stage 3: numerator; a convex combination times span never exceeds 2W bits
  ctl_t          s3_ctl_q;
  logic [W2-1:0] s3_num_d, s3_num_q;
  logic [W-1:0]  s3_span_q, s3_lvl_q;

  assign s3_num_d = s2_pa_q + s2_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else if (en_i) begin
      s1_ctl_q <= s1_ctl_d;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_a_q    <= s1_a_d;
      s1_b_q    <= s1_b_d;
      s1_wa_q   <= s1_wa_d;
      s1_wb_q   <= s1_wb_d;
      s1_span_q <= s1_span_d;
      s1_lvl_q  <= s1_lvl_d;
      s2_pa_q   <= s2_pa_d;
      s2_pb_q   <= s2_pb_d;
      s2_span_q <= s1_span_q;
      s2_lvl_q  <= s1_lvl_q;
      s3_num_q  <= s3_num_d;
      s3_span_q <= s2_span_q;
      s3_lvl_q  <= s2_lvl_q;
    end
  end

  assign ctl_o   = s3_ctl_q;
  assign num_o   = s3_num_q;
  assign span_o  = s3_span_q;
  assign level_o = s3_lvl_q;

  // A ramp word always has a nonzero span split exactly by its two weights
  a_ramp_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_ctl_q.valid && !s1_ctl_q.bypass |->
      (s1_span_q != '0) &&
      ((W+1)'(s1_wa_q) + (W+1)'(s1_wb_q) == (W+1)'(s1_span_q)))
    else $error("fim_blend: ramp weights do not match span");

  // An accepted pixel lands in stage 1
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(in_valid_i && en_i) |-> s1_ctl_q.valid)
    else $error("fim_blend: accepted pixel lost at stage 1");

endmodule

### sv/fim_divider.sv
// ----------------------------------------------------------------------------
// fim_divider: pipelined restoring divider
// One quotient bit per stage; the quotient fits the pixel width.
// ----------------------------------------------------------------------------
module fim_divider
  import fim_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DFLT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  logic [2*PIXEL_BITS-1:0] num_i,
  input  logic [PIXEL_BITS-1:0]   span_i,
  input  logic [PIXEL_BITS-1:0]   level_i,
  output ctl_t                    ctl_o,
  output logic [PIXEL_BITS-1:0]   quot_o,
  output logic [PIXEL_BITS-1:0]   level_o
);

  localparam int W = PIXEL_BITS;

  ctl_t         ctl_q  [W];
  logic [W-1:0] rem_q  [W];  // partial remainder, below span
  logic [W-1:0] nq_q   [W];  // dividend bits still to use, quotient bits shifted in
  logic [W-1:0] span_q [W];
  logic [W-1:0] lvl_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    ctl_t         ctl_in;
    logic [W-1:0] rem_in, nq_in, span_in, lvl_in;
    logic [W:0]   trial, diff;
    logic         qbit;
    logic [W-1:0] rem_d, nq_d;

    if (k == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign rem_in  = num_i[2*W-1:W];
      assign nq_in   = num_i[W-1:0];
      assign span_in = span_i;
      assign lvl_in  = level_i;
    end else begin : g_next
      assign ctl_in  = ctl_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign span_in = span_q[k-1];
      assign lvl_in  = lvl_q[k-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[W-1]};
      diff  = trial - {1'b0, span_in};
      qbit  = (trial >= {1'b0, span_in});
      rem_d = qbit ? diff[W-1:0] : trial[W-1:0];
      nq_d  = {nq_in[W-2:0], qbit};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        nq_q[k]   <= nq_d;
        span_q[k] <= span_in;
        lvl_q[k]  <= lvl_in;
      end
    end
  end

  assign ctl_o   = ctl_q[W-1];
  assign quot_o  = nq_q[W-1];
  assign level_o = lvl_q[W-1];

  // Final remainder of a ramp word stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[W-1].valid && !ctl_q[W-1].bypass |-> rem_q[W-1] < span_q[W-1])
    else $error("fim_divider: remainder not below span");

  // A frozen pipe keeps its last stage untouched
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(ctl_q[W-1]) && $stable(nq_q[W-1]))
    else $error("fim_divider: last stage moved while frozen");

endmodule
